/* rtl/core/ames_pkg.sv */
// Shared types and constants for the adjacency matrix edit store.
// No dependencies.
package ames_pkg;

  localparam int ROW_W  = 64;
  localparam int IDX_W  = 6;
  localparam int NODE_W = 7;
  localparam int EDGE_W = 13;
  localparam int CMD_W  = 3;
  localparam int ST_W   = 2;

  localparam logic [CMD_W-1:0] CMD_QUERY     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_EDGE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UNDO_EDGE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ADD_NODE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_UNDO_NODE = 3'd4;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
  localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;

  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_DIRECTED = 1'b1;

  localparam logic [NODE_W-1:0] CAP_RESET = 7'd64;
  localparam logic [EDGE_W-1:0] EDGE_MAX  = 13'h1FFF;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic rd_s;
    logic wr_s;
    logic rd_t;
    logic wr_t;
    logic commit;
  } ames_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic edge_op;
    logic mirror_wr;
    logic out_free;
  } ames_sts_t;

endpackage

/* rtl/core/ames_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ames_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/ames_ctrl.sv */
// Sequencer for the adjacency matrix edit store: steps in-range edge requests
// through row read, row and optional mirror update; all commit. Uses ames_pkg.
module ames_ctrl import ames_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ames_sts_t sts,
  output ames_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD_S = 6'b000010,
    S_EV_S = 6'b000100,
    S_RD_T = 6'b001000,
    S_EV_T = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RD_S;
        end
      end
      S_RD_S: begin
        if (sts.edge_op) begin
          cmd.rd_s  = 1'b1;
          state_nxt = S_EV_S;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_EV_S: begin
        cmd.wr_s  = 1'b1;
        state_nxt = sts.mirror_wr ? S_RD_T : S_FIN;
      end
      S_RD_T: begin
        cmd.rd_t  = 1'b1;
        state_nxt = S_EV_T;
      end
      S_EV_T: begin
        cmd.wr_t  = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/ames_dp.sv */
// Datapath: request and config registers, row store with per-row valid flags,
// node and edge counters, result register. Uses ames_pkg and ames_ram.
module ames_dp import ames_pkg::*; #(
  parameter int NODE_SLOTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ames_cmd_t          cmd,
  output ames_sts_t          sts,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [IDX_W-1:0]   in_source_node,
  input  logic [IDX_W-1:0]   in_target_node,
  input  logic               cfg_valid,
  input  logic               cfg_index,
  input  logic [NODE_W-1:0]  cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_edge_present,
  output logic [IDX_W-1:0]   out_new_node_index,
  output logic [NODE_W-1:0]  out_nodes_in_use,
  output logic [EDGE_W-1:0]  out_edges_in_use,
  output logic [ST_W-1:0]    out_status
);

  localparam int AW = $clog2(NODE_SLOTS);
  localparam logic [NODE_W-1:0] MaxN = NODE_W'(NODE_SLOTS);

  logic [CMD_W-1:0]      cmd_r;
  logic [IDX_W-1:0]      src_r, tgt_r;
  logic [NODE_W-1:0]     cap_r;
  logic                  dir_r;
  logic [NODE_W-1:0]     node_total_r, node_nxt;
  logic [EDGE_W-1:0]     edge_total_r, edge_nxt;
  logic                  present_r;
  logic [NODE_SLOTS-1:0] valid_r, valid_nxt;
  logic [AW-1:0]         rd_row_r;

  logic                 out_valid_r;
  logic                 out_present_r;
  logic [IDX_W-1:0]     out_idx_r;
  logic [NODE_W-1:0]    out_nodes_r;
  logic [EDGE_W-1:0]    out_edges_r;
  logic [ST_W-1:0]      out_status_r;

  logic                 idx_ok, edge_cmd, edge_op, bit_st, changes;
  logic                 rd_en, wr_en;
  logic [AW-1:0]        rd_addr, last_row;
  logic [ROW_W-1:0]     rd_data, row_cur, wr_data;
  logic [NODE_W-1:0]    cap_eff, node_dec;
  logic [EDGE_W:0]      by, sum;
  logic                 pres_nxt;
  logic [IDX_W-1:0]     idx_nxt;
  logic [ST_W-1:0]      st_nxt;

  assign idx_ok   = ({1'b0, src_r} < MaxN) && ({1'b0, tgt_r} < MaxN);
  assign edge_cmd = (cmd_r == CMD_QUERY) || (cmd_r == CMD_ADD_EDGE) ||
                    (cmd_r == CMD_UNDO_EDGE);
  assign edge_op  = edge_cmd && idx_ok;

  // rows never written since reset or since their node was undone read as zero
  assign row_cur  = valid_r[rd_row_r] ? rd_data : '0;
  assign bit_st   = row_cur[tgt_r];
  assign changes  = ((cmd_r == CMD_ADD_EDGE) && !bit_st) || (cmd_r == CMD_UNDO_EDGE);

  assign sts.edge_op   = edge_op;
  assign sts.mirror_wr = changes && !dir_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign rd_en   = cmd.rd_s || cmd.rd_t;
  assign rd_addr = cmd.rd_t ? tgt_r[AW-1:0] : src_r[AW-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_data = row_cur;
    if (cmd.wr_s && changes) begin
      wr_en          = 1'b1;
      wr_data[tgt_r] = (cmd_r == CMD_ADD_EDGE);
    end
    if (cmd.wr_t) begin
      wr_en          = 1'b1;
      wr_data[src_r] = (cmd_r == CMD_ADD_EDGE);
    end
  end

  ames_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NODE_SLOTS)
  ) u_rows (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (rd_row_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cap_eff  = (cap_r > MaxN) ? MaxN : cap_r;
  assign node_dec = node_total_r - NODE_W'(1);
  assign last_row = node_dec[AW-1:0];
  assign by       = dir_r ? (EDGE_W+1)'(1) : (EDGE_W+1)'(2);
  assign sum      = {1'b0, edge_total_r} + by;

  always_comb begin
    node_nxt = node_total_r;
    edge_nxt = edge_total_r;
    st_nxt   = ST_OK;
    pres_nxt = 1'b0;
    idx_nxt  = '0;
    case (cmd_r)
      CMD_QUERY: begin
        pres_nxt = edge_op && present_r;
      end
      CMD_ADD_EDGE: begin
        if (edge_op) begin
          pres_nxt = present_r;
          if (!present_r) begin
            edge_nxt = (sum > {1'b0, EDGE_MAX}) ? EDGE_MAX : sum[EDGE_W-1:0];
          end
        end
      end
      CMD_UNDO_EDGE: begin
        if (edge_op) begin
          pres_nxt = present_r;
          if ({1'b0, edge_total_r} < by) begin
            edge_nxt = '0;
            st_nxt   = ST_UNDERFLOW;
          end else begin
            edge_nxt = edge_total_r - by[EDGE_W-1:0];
          end
        end
      end
      CMD_ADD_NODE: begin
        if (node_total_r >= cap_eff) begin
          st_nxt = ST_FULL;
        end else begin
          idx_nxt  = node_total_r[IDX_W-1:0];
          node_nxt = node_total_r + NODE_W'(1);
        end
      end
      CMD_UNDO_NODE: begin
        if (node_total_r == '0) begin
          st_nxt = ST_UNDERFLOW;
        end else begin
          node_nxt = node_dec;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (wr_en) begin
      valid_nxt[rd_row_r] = 1'b1;
    end
    if (cmd.commit && (cmd_r == CMD_UNDO_NODE) && (node_total_r != '0)) begin
      valid_nxt[last_row] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r        <= CAP_RESET;
      dir_r        <= 1'b0;
      node_total_r <= '0;
      edge_total_r <= '0;
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && (cfg_index == CFG_CAPACITY)) begin
        cap_r <= cfg_data;
      end
      if (cfg_valid && (cfg_index == CFG_DIRECTED)) begin
        dir_r <= cfg_data[0];
      end
      valid_r <= valid_nxt;
      if (cmd.commit) begin
        node_total_r <= node_nxt;
        edge_total_r <= edge_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_command;
      src_r <= in_source_node;
      tgt_r <= in_target_node;
    end
    if (rd_en) begin
      rd_row_r <= rd_addr;
    end
    if (cmd.wr_s) begin
      present_r <= bit_st;
    end
    if (cmd.commit) begin
      out_present_r <= pres_nxt;
      out_idx_r     <= idx_nxt;
      out_nodes_r   <= node_nxt;
      out_edges_r   <= edge_nxt;
      out_status_r  <= st_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_edge_present   = out_present_r;
  assign out_new_node_index = out_idx_r;
  assign out_nodes_in_use   = out_nodes_r;
  assign out_edges_in_use   = out_edges_r;
  assign out_status         = out_status_r;

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("result committed over an untaken result");

  a_nodes_bound: assert property (@(posedge clk) disable iff (!rst_n)
    node_total_r <= MaxN)
    else $error("node count beyond store depth");

  a_undo_node: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && (cmd_r == CMD_UNDO_NODE) && (node_total_r != '0)) |=>
      (node_total_r == NODE_W'($past(node_total_r) - NODE_W'(1))) && !valid_r[$past(last_row)])
    else $error("undo node did not release its row");

endmodule

/* rtl/core/adjacency_matrix_edit_store.sv */
// Adjacency matrix edit store: one request at a time against a row store of
// NODE_SLOTS x 64 bits. Node requests, unused commands and out-of-range edge
// requests go from acceptance straight to result commit; queries and edge
// add/undo first read the source row and write it back if the edit changes it,
// and an undirected edit also updates the mirrored row, each row edit being a
// read-modify-write through the single read and write port of the row RAM. A
// request accepted while a result waits to be taken is still processed, but it
// holds in its final step; further acceptances wait until the result is taken.
// Rows are cleared at reset through per-row valid flags, so no clearing pass
// is needed. Uses ames_pkg, ames_ctrl, ames_dp.
module adjacency_matrix_edit_store import ames_pkg::*; #(
  parameter int NODE_SLOTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [IDX_W-1:0]   in_source_node,
  input  logic [IDX_W-1:0]   in_target_node,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_edge_present,
  output logic [IDX_W-1:0]   out_new_node_index,
  output logic [NODE_W-1:0]  out_nodes_in_use,
  output logic [EDGE_W-1:0]  out_edges_in_use,
  output logic [ST_W-1:0]    out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [NODE_W-1:0]  cfg_data
);

  ames_cmd_t cmd;
  ames_sts_t sts;

  assign cfg_ready = 1'b1;

  ames_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ames_dp #(
    .NODE_SLOTS (NODE_SLOTS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_command         (in_command),
    .in_source_node     (in_source_node),
    .in_target_node     (in_target_node),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_edge_present   (out_edge_present),
    .out_new_node_index (out_new_node_index),
    .out_nodes_in_use   (out_nodes_in_use),
    .out_edges_in_use   (out_edges_in_use),
    .out_status         (out_status)
  );

endmodule
